// ----- design/qts_pkg.sv -----
`default_nettype none

package qts_pkg;

   // fixed field widths of one word on each channel
   localparam int COEF_W = 17;
   localparam int TGT_W  = 34;
   localparam int OUT_W  = 18;

   // default upper end of the search range
   localparam int DEF_SEARCH_LIMIT = 131072;

   // query word as it travels down the pipeline
   typedef struct packed {
      logic [COEF_W-1:0] sq;
      logic [COEF_W-1:0] lin;
      logic [COEF_W-1:0] cst;
      logic [TGT_W-1:0]  tgt;
   } qts_item_type;

endpackage

`default_nettype wire

// ----- design/qts_req_if.sv -----
`default_nettype none

interface qts_req_if
   import qts_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [COEF_W-1:0] coef_sq;
   logic [COEF_W-1:0] coef_lin;
   logic [COEF_W-1:0] coef_const;
   logic [TGT_W-1:0]  target;

   modport source (output valid, output coef_sq, output coef_lin, output coef_const,
                   output target, input ready);
   modport sink   (input valid, input coef_sq, input coef_lin, input coef_const,
                   input target, output ready);

endinterface

`default_nettype wire

// ----- design/qts_rsp_if.sv -----
`default_nettype none

interface qts_rsp_if
   import qts_pkg::*;
   ();

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] least_x;

   modport source (output valid, output least_x, input ready);
   modport sink   (input valid, input least_x, output ready);

endinterface

`default_nettype wire

// ----- design/quadratic_threshold_search_unit.sv -----
// channel    dir  word                                    handshake
// req_chan   in   coef_sq, coef_lin, coef_const, target   valid / ready
// rsp_chan   out  least_x                                 valid / ready
//
// One word accepted per cycle while rsp_chan is not stalled; each word passes
// three register stages per halving step, then the result register.
// Synchronous reset clears the valid bits only; no state survives between words.
// A stalled rsp_chan freezes the whole pipeline and holds req_chan.ready low.
`default_nettype none

module quadratic_threshold_search_unit
   import qts_pkg::*;
   #(
      parameter int SEARCH_LIMIT = DEF_SEARCH_LIMIT
   )
   (
      input  wire     clock,
      input  wire     reset,
      qts_req_if.sink req_chan,
      qts_rsp_if.source rsp_chan
   );

   localparam int LW    = $clog2(SEARCH_LIMIT + 1);
   localparam int STEPS = LW;
   localparam int EW    = (LW > OUT_W) ? LW : OUT_W;

   logic                adv;
   logic [STEPS:0]      v;
   qts_item_type        item [STEPS+1];
   logic [LW-1:0]       lo   [STEPS+1];
   logic [LW-1:0]       hi   [STEPS+1];
   logic [EW-1:0]       hi_ext;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    least_x_ff;

   // pipeline moves whenever the output register can take a word
   assign adv           = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // search starts over the full range
   assign v[0]        = req_chan.valid;
   assign item[0].sq  = req_chan.coef_sq;
   assign item[0].lin = req_chan.coef_lin;
   assign item[0].cst = req_chan.coef_const;
   assign item[0].tgt = req_chan.target;
   assign lo[0]       = '0;
   assign hi[0]       = LW'(SEARCH_LIMIT);

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      qts_step #(.LW(LW)) u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (v[s]),
         .in_item   (item[s]),
         .in_lo     (lo[s]),
         .in_hi     (hi[s]),
         .out_valid (v[s+1]),
         .out_item  (item[s+1]),
         .out_lo    (lo[s+1]),
         .out_hi    (hi[s+1])
      );
   end

   // result register
   assign hi_ext       = EW'(hi[STEPS]);
   assign rsp_valid_in = adv ? v[STEPS] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         least_x_ff <= hi_ext[OUT_W-1:0];
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.least_x = least_x_ff;

   // search has converged by the last step
   a_converged : assert property (@(posedge clock) disable iff (reset)
      v[STEPS] |-> lo[STEPS] == hi[STEPS])
      else $error("qts: range not converged at pipeline end");

   // a new result only appears on an advancing cycle
   a_rsp_on_adv : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(adv))
      else $error("qts: result appeared without advance");

   // a stall freezes the output valid bit of every step
   a_stall_freeze : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v[STEPS:1]))
      else $error("qts: pipeline moved during stall");

endmodule

`default_nettype wire

// ----- design/qts_step.sv -----
`default_nettype none

// One halving of the search range, cut into three register stages:
//   1: midpoint, t = sq*mid + lin
//   2: p = t*mid + cst, mid + 1
//   3: compare p against the target, narrow [lo, hi]
module qts_step
   import qts_pkg::*;
   #(
      parameter int LW = 18
   )
   (
      input  wire                  clock,
      input  wire                  reset,
      input  wire                  adv,
      input  wire                  in_valid,
      input  qts_item_type         in_item,
      input  wire [LW-1:0]         in_lo,
      input  wire [LW-1:0]         in_hi,
      output logic                 out_valid,
      output qts_item_type         out_item,
      output logic [LW-1:0]        out_lo,
      output logic [LW-1:0]        out_hi
   );

   localparam int TW = COEF_W + LW + 1;
   localparam int PW = TW + LW + 1;
   localparam int CW = (PW > TGT_W) ? PW : TGT_W;

   // stage 1
   logic [LW:0]     sum;
   logic [LW-1:0]   mid;
   logic            v1_ff;
   logic            active1_ff, active1_in;
   logic [LW-1:0]   mid1_ff;
   logic [TW-1:0]   t1_ff, t1_in;
   qts_item_type    item1_ff;
   logic [LW-1:0]   lo1_ff, hi1_ff;

   // stage 2
   logic            v2_ff;
   logic            active2_ff;
   logic [LW-1:0]   mid2_ff, nxt2_ff, nxt2_in;
   logic [PW-1:0]   p2_ff, p2_in;
   qts_item_type    item2_ff;
   logic [LW-1:0]   lo2_ff, hi2_ff;

   // stage 3
   logic            v3_ff;
   logic            ge;
   qts_item_type    item3_ff;
   logic [LW-1:0]   lo3_ff, lo3_in, hi3_ff, hi3_in;

   // midpoint and inner Horner term
   assign sum        = {1'b0, in_lo} + {1'b0, in_hi};
   assign mid        = sum[LW:1];
   assign active1_in = in_lo < in_hi;
   assign t1_in      = TW'(in_item.sq) * TW'(mid) + TW'(in_item.lin);

   // outer Horner term and the step past the midpoint
   assign p2_in   = PW'(t1_ff) * PW'(mid1_ff) + PW'(item1_ff.cst);
   assign nxt2_in = mid1_ff + LW'(1);

   // keep the half that still holds the least qualifying x
   assign ge = CW'(p2_ff) >= CW'(item2_ff.tgt);

   always_comb begin
      lo3_in = lo2_ff;
      hi3_in = hi2_ff;
      if (active2_ff) begin
         if (ge) begin
            hi3_in = mid2_ff;
         end else begin
            lo3_in = nxt2_ff;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         active1_ff <= active1_in;
         mid1_ff    <= mid;
         t1_ff      <= t1_in;
         item1_ff   <= in_item;
         lo1_ff     <= in_lo;
         hi1_ff     <= in_hi;

         active2_ff <= active1_ff;
         mid2_ff    <= mid1_ff;
         nxt2_ff    <= nxt2_in;
         p2_ff      <= p2_in;
         item2_ff   <= item1_ff;
         lo2_ff     <= lo1_ff;
         hi2_ff     <= hi1_ff;

         item3_ff   <= item2_ff;
         lo3_ff     <= lo3_in;
         hi3_ff     <= hi3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;
   assign out_lo    = lo3_ff;
   assign out_hi    = hi3_ff;

   // range never inverts
   a_range_order : assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> lo3_ff <= hi3_ff)
      else $error("qts_step: lo above hi");

   // a converged range passes through unchanged
   a_idle_hold : assert property (@(posedge clock) disable iff (reset)
      adv && v2_ff && !active2_ff |=> lo3_ff == $past(lo2_ff) && hi3_ff == $past(hi2_ff))
      else $error("qts_step: converged range altered");

endmodule

`default_nettype wire
